@@ rtl/rpvg_pkg.sv @@
// Shared types, constants and helpers for the regular polygon vertex generator.
// No dependencies.
package rpvg_pkg;

  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned RADIUS_W     = 10;
  localparam int unsigned START_W      = 16;
  localparam int unsigned COORD_W      = 11;
  localparam int unsigned INDEX_W      = 6;
  localparam int unsigned IN_DATA_W    = 40;
  localparam int unsigned OUT_DATA_W   = 32;
  localparam int unsigned Q15_W        = 16;
  localparam int unsigned PHASE_BITS   = 20;
  localparam int unsigned CORDIC_STEPS = 18;
  localparam int unsigned ITER_W       = 5;
  localparam int unsigned CORD_W       = 32;
  localparam int unsigned ZACC_W       = 20;
  localparam int unsigned REM_W        = 8;

  localparam logic signed [CORD_W-1:0] GAIN_INIT = 32'sd652032874;

  typedef struct packed {
    logic signed [Q15_W-1:0] cos_q15;
    logic signed [Q15_W-1:0] sin_q15;
  } sincos_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DIV    = 6'b000010,
    ST_CORDIC = 6'b000100,
    ST_MULX   = 6'b001000,
    ST_MULY   = 6'b010000,
    ST_EMIT   = 6'b100000
  } seq_state_e;

  // atan(2^-i) in 2^20 units per turn
  function automatic logic signed [ZACC_W-1:0] atan_units(input logic [ITER_W-1:0] idx);
    logic signed [ZACC_W-1:0] v;
    unique case (idx)
      5'd0:    v = 20'sd131072;
      5'd1:    v = 20'sd77376;
      5'd2:    v = 20'sd40884;
      5'd3:    v = 20'sd20753;
      5'd4:    v = 20'sd10416;
      5'd5:    v = 20'sd5213;
      5'd6:    v = 20'sd2607;
      5'd7:    v = 20'sd1304;
      5'd8:    v = 20'sd652;
      5'd9:    v = 20'sd326;
      5'd10:   v = 20'sd163;
      5'd11:   v = 20'sd81;
      5'd12:   v = 20'sd41;
      5'd13:   v = 20'sd20;
      5'd14:   v = 20'sd10;
      5'd15:   v = 20'sd5;
      5'd16:   v = 20'sd3;
      5'd17:   v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [Q15_W-1:0] sat_q15(input logic signed [17:0] v);
    logic signed [Q15_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sd32767;
    end else if (v < -18'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = v[Q15_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/rpvg_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, for the angle step.
// Depends on rpvg_pkg.
module rpvg_divider #(
  parameter int unsigned NUM_W = 17
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [NUM_W-1:0]                   num_i,
  input  logic [rpvg_pkg::COUNT_W-1:0]       den_i,
  output logic                               done_o,
  output logic [NUM_W-1:0]                   quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic                          busy_q, done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [NUM_W-1:0]              num_q, quot_q;
  logic [rpvg_pkg::REM_W-1:0]    rem_q;
  logic [rpvg_pkg::COUNT_W-1:0]  den_q;

  logic [rpvg_pkg::REM_W-1:0]    rem_sh, rem_nx, den_ext;
  logic                          ge;

  assign den_ext = {1'b0, den_q};
  assign rem_sh  = {rem_q[rpvg_pkg::REM_W-2:0], num_q[NUM_W-1]};
  assign ge      = rem_sh >= den_ext;
  assign rem_nx  = ge ? rem_sh - den_ext : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      rem_q  <= rem_nx;
      quot_q <= {quot_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/rpvg_cordic.sv @@
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q1.15 sin/cos.
// Depends on rpvg_pkg.
module rpvg_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rpvg_pkg::PHASE_BITS-1:0]     phase_i,
  output logic                                done_o,
  output rpvg_pkg::sincos_t                   result_o
);

  localparam int unsigned CW = rpvg_pkg::CORD_W;
  localparam int unsigned ZW = rpvg_pkg::ZACC_W;
  localparam int unsigned IW = rpvg_pkg::ITER_W;

  logic                 busy_q, done_q;
  logic [IW-1:0]        iter_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [1:0]           quad_q;

  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] atn;
  logic signed [CW:0]   xr_sum, yr_sum;
  logic signed [17:0]   xr, yr;
  logic signed [rpvg_pkg::Q15_W-1:0] c_q15, s_q15;

  assign dx  = y_q >>> iter_q;
  assign dy  = x_q >>> iter_q;
  assign atn = rpvg_pkg::atan_units(iter_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + IW'(1);
        if (iter_q == IW'(rpvg_pkg::CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rpvg_pkg::GAIN_INIT;
      y_q    <= '0;
      z_q    <= $signed({2'b00, phase_i[rpvg_pkg::PHASE_BITS-3:0]});
      quad_q <= phase_i[rpvg_pkg::PHASE_BITS-1 -: 2];
    end else if (busy_q) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atn;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atn;
      end
    end
  end

  // round half up to Q1.15
  assign xr_sum = {x_q[CW-1], x_q} + (CW+1)'(16384);
  assign yr_sum = {y_q[CW-1], y_q} + (CW+1)'(16384);
  assign xr     = xr_sum[CW:15];
  assign yr     = yr_sum[CW:15];
  assign c_q15  = rpvg_pkg::sat_q15(xr);
  assign s_q15  = rpvg_pkg::sat_q15(yr);

  always_comb begin
    unique case (quad_q)
      2'd0: begin
        result_o.cos_q15 = c_q15;
        result_o.sin_q15 = s_q15;
      end
      2'd1: begin
        result_o.cos_q15 = -s_q15;
        result_o.sin_q15 = c_q15;
      end
      2'd2: begin
        result_o.cos_q15 = -c_q15;
        result_o.sin_q15 = -s_q15;
      end
      default: begin
        result_o.cos_q15 = s_q15;
        result_o.sin_q15 = -c_q15;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

@@ rtl/regular_polygon_vertex_generator.sv @@
// Regular polygon vertex generator: top level with the per-vertex sequencer.
// Depends on rpvg_pkg, rpvg_divider and rpvg_cordic.
//
// One request beat (count, radius, start angle) produces count vertex beats, the
// last one flagged by tlast; a count of zero produces none and a count above
// MAX_VERTICES is clipped. The block takes one request at a time. After the
// request is taken, the angle step is found by a bit-serial divider; then each
// vertex runs through the iterative CORDIC, a capture of its sin/cos, the
// shared radius multiplier (x, then y) and a load into the output register,
// which waits while that register holds a vertex not yet taken. A vertex waits
// in the output register while the next one is computed; the next request is
// taken as soon as the last vertex is loaded.
module regular_polygon_vertex_generator #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned ANGLE_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [6:0] vertex_count, [16:7] shape_radius, [32:17] start_turn, [39:33] zero
  input  logic [rpvg_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [10:0] vertex_x, [21:11] vertex_y, [27:22] vertex_index, [31:28] zero
  output logic [rpvg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // last_vertex
  output logic                                m_axis_tlast
);

  localparam int unsigned CNT_W  = rpvg_pkg::COUNT_W;
  localparam int unsigned RAD_W  = rpvg_pkg::RADIUS_W;
  localparam int unsigned STW    = rpvg_pkg::START_W;
  localparam int unsigned XW     = rpvg_pkg::COORD_W;
  localparam int unsigned QW     = rpvg_pkg::Q15_W;
  localparam int unsigned PB     = rpvg_pkg::PHASE_BITS;
  localparam int unsigned NUM_W  = ANGLE_BITS + 1;
  localparam int unsigned PROD_W = RAD_W + QW + 1;

  rpvg_pkg::seq_state_e state_q, state_d;

  logic [CNT_W-1:0]      count_q, counter_q;
  logic [RAD_W-1:0]      radius_q;
  logic [ANGLE_BITS-1:0] accum_q, step_q;
  logic signed [QW-1:0]  cq_q, sq_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [XW-1:0]  vx_q;
  logic                  out_valid_q;
  logic [rpvg_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                  out_last_q;

  logic                  in_fire, out_fire, emit, is_last;
  logic [CNT_W-1:0]      count_in, count_sat;
  logic [RAD_W-1:0]      radius_in;
  logic [STW-1:0]        start_in;
  logic [ANGLE_BITS+STW-1:0] start_wide;
  logic [ANGLE_BITS-1:0] accum_load, accum_next, phase_src;
  logic [ANGLE_BITS+PB-1:0]  phase_wide;
  logic [NUM_W-1:0]      div_num, div_quot;
  logic                  div_start, div_done, cor_start, cor_done;
  rpvg_pkg::sincos_t     cor_res;
  logic signed [QW-1:0]  mul_op;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [XW-1:0]  vy;

  function automatic logic signed [XW-1:0] scale_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0]         s;
    logic signed [PROD_W-15:0]      v;
    logic signed [XW-1:0]           r;
    s = {p[PROD_W-1], p} + (PROD_W+1)'(16384);
    v = s[PROD_W:15];
    if (v > (PROD_W-14)'(1023)) begin
      r = 11'sd1023;
    end else if (v < -(PROD_W-14)'(1023)) begin
      r = -11'sd1023;
    end else begin
      r = v[XW-1:0];
    end
    return r;
  endfunction

  assign count_in  = s_axis_tdata[CNT_W-1:0];
  assign radius_in = s_axis_tdata[CNT_W +: RAD_W];
  assign start_in  = s_axis_tdata[CNT_W+RAD_W +: STW];
  assign count_sat = (count_in > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_in;

  assign start_wide = {start_in, {ANGLE_BITS{1'b0}}} >> STW;
  assign accum_load = start_wide[ANGLE_BITS-1:0];

  assign s_axis_tready = (state_q == rpvg_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;

  assign div_num   = {1'b1, {ANGLE_BITS{1'b0}}} + NUM_W'(count_sat >> 1);
  assign div_start = in_fire && (count_sat != '0);

  assign accum_next = accum_q + step_q;
  assign is_last    = (counter_q + CNT_W'(1)) == count_q;
  assign emit       = (state_q == rpvg_pkg::ST_EMIT) && (!out_valid_q || m_axis_tready);

  assign phase_src  = (state_q == rpvg_pkg::ST_EMIT) ? accum_next : accum_q;
  assign phase_wide = {phase_src, {PB{1'b0}}} >> ANGLE_BITS;
  assign cor_start  = ((state_q == rpvg_pkg::ST_DIV) && div_done) || (emit && !is_last);

  assign mul_op = (state_q == rpvg_pkg::ST_MULX) ? cq_q : sq_q;
  assign prod_d = $signed({{(QW+1){1'b0}}, radius_q}) * $signed({{(RAD_W+1){mul_op[QW-1]}}, mul_op});
  assign vy     = scale_round(prod_q);

  rpvg_divider #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (count_sat),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  rpvg_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cor_start),
    .phase_i  (phase_wide[PB-1:0]),
    .done_o   (cor_done),
    .result_o (cor_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rpvg_pkg::ST_IDLE: begin
        if (div_start) begin
          state_d = rpvg_pkg::ST_DIV;
        end
      end
      rpvg_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = rpvg_pkg::ST_CORDIC;
        end
      end
      rpvg_pkg::ST_CORDIC: begin
        if (cor_done) begin
          state_d = rpvg_pkg::ST_MULX;
        end
      end
      rpvg_pkg::ST_MULX: state_d = rpvg_pkg::ST_MULY;
      rpvg_pkg::ST_MULY: state_d = rpvg_pkg::ST_EMIT;
      rpvg_pkg::ST_EMIT: begin
        if (emit) begin
          state_d = is_last ? rpvg_pkg::ST_IDLE : rpvg_pkg::ST_CORDIC;
        end
      end
      default: state_d = rpvg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpvg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      counter_q   <= '0;
      count_q     <= '0;
      accum_q     <= '0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        count_q   <= count_sat;
        counter_q <= '0;
        accum_q   <= accum_load;
        step_q    <= '0;
      end else begin
        if ((state_q == rpvg_pkg::ST_DIV) && div_done) begin
          step_q <= div_quot[ANGLE_BITS-1:0];
        end
        if (emit) begin
          accum_q   <= accum_next;
          counter_q <= counter_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      radius_q <= radius_in;
    end
    if ((state_q == rpvg_pkg::ST_CORDIC) && cor_done) begin
      cq_q <= cor_res.cos_q15;
      sq_q <= cor_res.sin_q15;
    end
    if ((state_q == rpvg_pkg::ST_MULX) || (state_q == rpvg_pkg::ST_MULY)) begin
      prod_q <= prod_d;
    end
    if (state_q == rpvg_pkg::ST_MULY) begin
      vx_q <= scale_round(prod_q);
    end
    if (emit) begin
      out_data_q <= {4'b0000, counter_q[rpvg_pkg::INDEX_W-1:0], vy, vx_q};
      out_last_q <= is_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
